>>> rtl/core/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the postfix integer evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int DATA_WIDTH          = 32;
   localparam int STACK_DEPTH_DEFAULT = 32;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MOD = 3'd4,
      OP_POW = 3'd5
   } op_code_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_SYNTAX = 2'd1,
      STATUS_DIVZ   = 2'd2
   } status_type;

   typedef struct packed {
      logic        start;
      op_code_type code;
   } alu_req_type;

   typedef struct packed {
      logic       done;
      status_type status;
   } alu_rsp_type;

endpackage

>>> rtl/core/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/pfe_alu.sv
// ----------------------------------------------------------------------------
// pfe_alu
// Iterative arithmetic unit: add, sub, multiply, power by square and
// multiply on one shared multiplier, signed divide and modulo by restoring
// division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfe_alu (
   input  logic                             clock,
   input  logic                             reset,
   input  pfe_pkg::alu_req_type             alu_req,
   input  logic [pfe_pkg::DATA_WIDTH-1:0]   left,
   input  logic [pfe_pkg::DATA_WIDTH-1:0]   right,
   output pfe_pkg::alu_rsp_type             alu_rsp,
   output logic [pfe_pkg::DATA_WIDTH-1:0]   result
);

   localparam int DW = pfe_pkg::DATA_WIDTH;
   localparam int SW = $clog2(DW);

   typedef enum logic [2:0] {
      ALU_IDLE,
      ALU_MUL,
      ALU_POW_A,
      ALU_POW_B,
      ALU_DIV,
      ALU_FIX,
      ALU_DONE
   } alu_state_type;

   alu_state_type        state_ff;
   pfe_pkg::op_code_type code_ff;
   pfe_pkg::status_type  status_ff;
   logic [DW-1:0]        a_ff;
   logic [DW-1:0]        b_ff;
   logic [DW-1:0]        acc_ff;
   logic [SW-1:0]        step_ff;
   logic                 neg_q_ff;
   logic                 neg_r_ff;

   logic [DW-1:0]   mul_x;
   logic [DW-1:0]   mul_y;
   logic [DW-1:0]   mul_lo;
   logic [DW:0]     shifted;
   logic [DW:0]     diff;
   logic [DW-1:0]   left_mag;
   logic [DW-1:0]   right_mag;
   logic [DW-1:0]   b_next;

   assign mul_x  = (state_ff == ALU_POW_A) ? acc_ff : a_ff;
   assign mul_y  = (state_ff == ALU_MUL) ? b_ff : a_ff;
   assign mul_lo = mul_x * mul_y;

   assign shifted = {acc_ff, b_ff[DW-1]};
   assign diff    = shifted - {1'b0, a_ff};

   assign left_mag  = left[DW-1] ? (~left + DW'(1)) : left;
   assign right_mag = right[DW-1] ? (~right + DW'(1)) : right;
   assign b_next    = {1'b0, b_ff[DW-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
      end else begin
         unique case (state_ff)
            ALU_IDLE: begin
               if (alu_req.start) begin
                  code_ff <= alu_req.code;
                  case (alu_req.code) inside
                     pfe_pkg::OP_ADD: begin
                        status_ff <= pfe_pkg::STATUS_OK;
                        acc_ff    <= left + right;
                        state_ff  <= ALU_DONE;
                     end
                     pfe_pkg::OP_SUB: begin
                        status_ff <= pfe_pkg::STATUS_OK;
                        acc_ff    <= left - right;
                        state_ff  <= ALU_DONE;
                     end
                     pfe_pkg::OP_MUL: begin
                        status_ff <= pfe_pkg::STATUS_OK;
                        a_ff      <= left;
                        b_ff      <= right;
                        state_ff  <= ALU_MUL;
                     end
                     pfe_pkg::OP_DIV, pfe_pkg::OP_MOD: begin
                        if (right == '0) begin
                           status_ff <= pfe_pkg::STATUS_DIVZ;
                           state_ff  <= ALU_DONE;
                        end else begin
                           status_ff <= pfe_pkg::STATUS_OK;
                           a_ff      <= right_mag;
                           b_ff      <= left_mag;
                           acc_ff    <= '0;
                           step_ff   <= '0;
                           neg_q_ff  <= left[DW-1] ^ right[DW-1];
                           neg_r_ff  <= left[DW-1];
                           state_ff  <= ALU_DIV;
                        end
                     end
                     pfe_pkg::OP_POW: begin
                        status_ff <= pfe_pkg::STATUS_OK;
                        a_ff      <= left;
                        b_ff      <= right;
                        if (right[DW-1]) begin
                           acc_ff   <= '0;
                           state_ff <= ALU_DONE;
                        end else begin
                           acc_ff   <= DW'(1);
                           state_ff <= (right != '0) ? ALU_POW_A : ALU_DONE;
                        end
                     end
                     default: begin
                        status_ff <= pfe_pkg::STATUS_SYNTAX;
                        state_ff  <= ALU_DONE;
                     end
                  endcase
               end
            end
            ALU_MUL: begin
               acc_ff   <= mul_lo;
               state_ff <= ALU_DONE;
            end
            ALU_POW_A: begin
               if (b_ff[0]) begin
                  acc_ff <= mul_lo;
               end
               state_ff <= ALU_POW_B;
            end
            ALU_POW_B: begin
               a_ff     <= mul_lo;
               b_ff     <= b_next;
               state_ff <= (b_next == '0) ? ALU_DONE : ALU_POW_A;
            end
            ALU_DIV: begin
               if (!diff[DW]) begin
                  acc_ff <= diff[DW-1:0];
                  b_ff   <= {b_ff[DW-2:0], 1'b1};
               end else begin
                  acc_ff <= shifted[DW-1:0];
                  b_ff   <= {b_ff[DW-2:0], 1'b0};
               end
               step_ff <= step_ff + SW'(1);
               if (step_ff == SW'(DW - 1)) begin
                  state_ff <= ALU_FIX;
               end
            end
            ALU_FIX: begin
               if (code_ff == pfe_pkg::OP_DIV) begin
                  acc_ff <= neg_q_ff ? (~b_ff + DW'(1)) : b_ff;
               end else begin
                  acc_ff <= neg_r_ff ? (~acc_ff + DW'(1)) : acc_ff;
               end
               state_ff <= ALU_DONE;
            end
            ALU_DONE: state_ff <= ALU_IDLE;
            default:  state_ff <= ALU_IDLE;
         endcase
      end
   end

   assign alu_rsp.done   = (state_ff == ALU_DONE);
   assign alu_rsp.status = status_ff;
   assign result         = acc_ff;

endmodule

>>> rtl/core/postfix_integer_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_integer_evaluator
// Evaluates a postfix integer expression streamed one token per transaction.
// ----------------------------------------------------------------------------
// Numbers are pushed onto an operand stack held in RAM with the top value
// mirrored in a register; operators pop two values and push the result,
// wrapping at 32 bits. The token marked last returns one result transaction
// (value and status: ok, syntax error or division by zero) and clears the
// stack for the next expression. The block takes one token at a time: it
// accepts a new one only when idle, after the last one is done. Divide and
// modulo produce one quotient bit per cycle, and power makes two passes
// through the shared multiplier per exponent bit up to the highest set bit.
// A last token then loads the result register once it is free; that
// register may hold a result while the next expression streams in.
// ----------------------------------------------------------------------------
module postfix_integer_evaluator #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic signed [pfe_pkg::DATA_WIDTH-1:0] req_number,
   input  logic [2:0]                            req_operator_code,
   input  logic                                  req_last_token,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pfe_pkg::DATA_WIDTH-1:0] rsp_value,
   output logic [1:0]                            rsp_status
);

   localparam int DW = pfe_pkg::DATA_WIDTH;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_LAST
   } eval_state_type;

   eval_state_type              state_ff;
   logic [CW-1:0]               count_ff;
   pfe_pkg::status_type         err_ff;
   logic [DW-1:0]               tos_ff;
   logic [2:0]                  code_ff;
   logic                        last_ff;
   logic                        rsp_valid_ff;
   logic signed [DW-1:0]        rsp_value_ff;
   pfe_pkg::status_type         rsp_status_ff;

   logic                        accept;
   logic                        full;
   logic [CW-1:0]               count_m2;
   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [DW-1:0]               ram_wr_data;
   logic [DW-1:0]               ram_rd_data;
   pfe_pkg::alu_req_type        alu_req;
   pfe_pkg::alu_rsp_type        alu_rsp;
   logic [DW-1:0]               alu_result;
   logic                        slot_free;
   pfe_pkg::status_type         final_status;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(STACK_DEPTH));
   assign count_m2  = count_ff - CW'(2);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign alu_req.start = (state_ff == ST_READ);
   assign alu_req.code  = pfe_pkg::op_code_type'(code_ff);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = $unsigned(req_number);
      if (state_ff == ST_WAIT) begin
         ram_wr_en   = alu_rsp.done && (alu_rsp.status == pfe_pkg::STATUS_OK);
         ram_wr_addr = count_m2[AW-1:0];
         ram_wr_data = alu_result;
      end else if (accept && (err_ff == pfe_pkg::STATUS_OK) && !req_op && !full) begin
         ram_wr_en = 1'b1;
      end
   end

   always_comb begin
      if (err_ff != pfe_pkg::STATUS_OK) begin
         final_status = err_ff;
      end else if (count_ff != CW'(1)) begin
         final_status = pfe_pkg::STATUS_SYNTAX;
      end else begin
         final_status = pfe_pkg::STATUS_OK;
      end
   end

   pfe_ram #(
      .WIDTH (DW),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (count_m2[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   pfe_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .left    (ram_rd_data),
      .right   (tos_ff),
      .alu_rsp (alu_rsp),
      .result  (alu_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         err_ff       <= pfe_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_LAST)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  code_ff <= req_operator_code;
                  last_ff <= req_last_token;
                  if ((err_ff == pfe_pkg::STATUS_OK) && req_op && (count_ff >= CW'(2))) begin
                     state_ff <= ST_READ;
                  end else if (req_last_token) begin
                     state_ff <= ST_LAST;
                  end
                  if (err_ff == pfe_pkg::STATUS_OK) begin
                     if (!req_op) begin
                        if (full) begin
                           err_ff <= pfe_pkg::STATUS_SYNTAX;
                        end else begin
                           tos_ff   <= $unsigned(req_number);
                           count_ff <= count_ff + CW'(1);
                        end
                     end else if (count_ff < CW'(2)) begin
                        err_ff <= pfe_pkg::STATUS_SYNTAX;
                     end
                  end
               end
            end
            ST_READ: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (alu_rsp.done) begin
                  if (alu_rsp.status == pfe_pkg::STATUS_OK) begin
                     tos_ff   <= alu_result;
                     count_ff <= count_ff - CW'(1);
                  end else begin
                     err_ff <= alu_rsp.status;
                  end
                  state_ff <= last_ff ? ST_LAST : ST_IDLE;
               end
            end
            ST_LAST: begin
               if (slot_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= final_status;
                  rsp_value_ff  <= (final_status == pfe_pkg::STATUS_OK) ?
                                   $signed(tos_ff) : '0;
                  count_ff      <= '0;
                  err_ff        <= pfe_pkg::STATUS_OK;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule
